// ===== design/ssd_pkg.sv =====
// Shared constants, types and character helpers for the selector string decoder.
`timescale 1ns / 1ps
package ssd_pkg;

	// Sizes
	localparam int MAX_CHARS = 128;
	localparam int MAX_SEL   = 64;
	localparam int CCW       = $clog2(MAX_CHARS + 1);  // character count width
	localparam int CAW       = $clog2(MAX_CHARS);      // character store address width
	localparam int SCW       = $clog2(MAX_SEL + 1);    // selector count width
	localparam int SAW       = $clog2(MAX_SEL);        // selector buffer address width

	// Configuration port
	localparam int CFG_AW = 1;
	localparam int CFG_DW = 7;
	localparam logic [CFG_AW-1:0] REG_LITERAL_MODE    = 1'd0;
	localparam logic [CFG_AW-1:0] REG_SELECTOR_LENGTH = 1'd1;
	localparam logic [CFG_DW-1:0] SEL_LEN_RESET       = 7'd64;

	// Characters
	localparam logic [7:0] CH_BSL   = 8'h5c;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// Result codes
	localparam logic [1:0] FORM_HEX  = 2'd0;
	localparam logic [1:0] FORM_HASH = 2'd1;
	localparam logic [1:0] FORM_LIT  = 2'd2;
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_OVF   = 2'd2;

	typedef enum logic [4:0] {
		S_LOAD,
		S_DECIDE,
		S_HASH_CHK,
		S_X_FETCH,
		S_X_HI,
		S_X_LO_RD,
		S_X_LO,
		S_H_FETCH,
		S_H_EX,
		S_H_WR_HI,
		S_H_WR_LO,
		S_L_FETCH,
		S_L_EX,
		S_L_ESC_RD,
		S_L_ESC,
		S_L_UNK,
		S_N_FETCH,
		S_N_EX,
		S_N_END,
		S_E_RD,
		S_E_OUT,
		S_E_NONE
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PREP_STATUS,
		OP_HEX_BEGIN,
		OP_HEX_HI,
		OP_HEX_LO,
		OP_HASH_BEGIN,
		OP_HASH_STEP,
		OP_HASH_WR_HI,
		OP_HASH_WR_LO,
		OP_LIT_BEGIN,
		OP_LIT_CHAR,
		OP_LIT_SKIP,
		OP_LIT_ESC,
		OP_LIT_UNK,
		OP_NUM_STEP,
		OP_NUM_END,
		OP_LIT_END,
		OP_EMIT_BYTE,
		OP_EMIT_STATUS
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   clear;     // string done: return load state to reset values
	} ctl_cmd_t;

	typedef struct packed {
		logic in_end;        // current request ends the string
		logic no_content;    // overflowed or empty string
		logic hex_ok;        // hex form applies
		logic literal_mode;
		logic is_hash;       // fetched character is '#'
		logic p_end;         // read pointer at string end
		logic pos_full;      // selector buffer full
		logic hex_done;      // all hex pairs packed
		logic hash_stop;     // fetched character ends the decimal parse
		logic is_bsl;        // fetched character is a backslash
		logic bsl_trailing;  // backslash is the final character
		logic esc_dec;       // escape starts a numeric code
		logic esc_mapped;    // escape has a fixed translation
		logic room_two;      // two more bytes fit
		logic num_dec;       // fetched character is a decimal digit
		logic elen_zero;     // nothing to emit
		logic emit_last;     // current emit index is the final byte
		logic out_space;     // output register can take a result
	} dp_status_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
	endfunction

	function automatic logic [3:0] hex_nib(input logic [7:0] c);
		logic [7:0] v;
		if (is_dec(c)) begin
			v = c - CH_ZERO;
		end else if ((c >= 8'h61) && (c <= 8'h66)) begin
			v = c - 8'h57;
		end else begin
			v = c - 8'h37;
		end
		return v[3:0];
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0d));
	endfunction

	function automatic logic esc_known(input logic [7:0] c);
		return (c == 8'h62) || (c == 8'h66) || (c == 8'h6e) || (c == 8'h72) || (c == 8'h74) ||
			(c == CH_BSL);
	endfunction

	function automatic logic [7:0] esc_map(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			8'h62:   r = 8'h08;  // \b
			8'h66:   r = 8'h0c;  // \f
			8'h6e:   r = 8'h0a;  // \n
			8'h72:   r = 8'h0d;  // \r
			8'h74:   r = 8'h09;  // \t
			default: r = CH_BSL;
		endcase
		return r;
	endfunction

endpackage

// ===== design/selector_string_decoder_top.sv =====
// Top level of the selector string decoder: sequencer plus datapath.
`timescale 1ns / 1ps
// Usage
//  Input channel (in_valid/in_ready): one request per string character, in_last on the
//  final one; in_empty ends a string that has no characters. Characters load at one per
//  cycle into a 128-entry character store.
//  Output channel (out_valid/out_ready): one result per selector byte, out_last on the
//  final one; empty or oversize strings give a single status-only result.
//  Config port (cfg_we/cfg_addr/cfg_wdata): index 0 literal_mode, index 1 selector_length;
//  write only while the block is idle.
//  Sequence: after the final character the decode walk reads the store through its single
//  registered read port, then the emit walk steps through the selector bytes; in_ready is
//  low from the final character until the last result enters the output register.
//  Reset: clears the load state and the output valid flag; literal_mode = 0,
//  selector_length = 64. The character store needs no clearing pass.
//  Stall: a result waits in the output register while out_ready is low; the emit walk of
//  the same string pauses until it is taken.
module selector_string_decoder_top import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  logic              in_empty,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [5:0]        byte_index,
	output logic              out_last,
	output logic              out_valid_byte,
	output logic [1:0]        form,
	output logic [1:0]        status,
	output logic [6:0]        result_count
);

	ctl_cmd_t   cmd;
	dp_status_t stat;

	ssd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssd_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_char        (in_char),
		.in_last        (in_last),
		.in_empty       (in_empty),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_index     (byte_index),
		.out_last       (out_last),
		.out_valid_byte (out_valid_byte),
		.form           (form),
		.status         (status),
		.result_count   (result_count)
	);

endmodule

// ===== design/ssd_ctrl.sv =====
// Sequencer for the selector string decoder: load, decode and emit phases.
`timescale 1ns / 1ps
module ssd_ctrl import ssd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t stat,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid && stat.in_end) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.no_content) state_d = S_E_NONE;
				else if (stat.hex_ok) state_d = S_X_FETCH;
				else if (stat.literal_mode) state_d = S_L_FETCH;
				else state_d = S_HASH_CHK;
			end
			S_HASH_CHK: state_d = stat.is_hash ? S_H_FETCH : S_L_FETCH;
			// hex pairs
			S_X_FETCH:  state_d = stat.hex_done ? S_E_RD : S_X_HI;
			S_X_HI:     state_d = S_X_LO_RD;
			S_X_LO_RD:  state_d = S_X_LO;
			S_X_LO:     state_d = S_X_FETCH;
			// hash decimal
			S_H_FETCH:  state_d = stat.p_end ? S_H_WR_HI : S_H_EX;
			S_H_EX:     state_d = stat.hash_stop ? S_H_WR_HI : S_H_FETCH;
			S_H_WR_HI:  state_d = S_H_WR_LO;
			S_H_WR_LO:  state_d = S_E_RD;
			// escaped literal
			S_L_FETCH:  state_d = (stat.p_end || stat.pos_full) ? S_E_RD : S_L_EX;
			S_L_EX: begin
				if (stat.is_bsl && !stat.bsl_trailing) state_d = S_L_ESC_RD;
				else state_d = S_L_FETCH;
			end
			S_L_ESC_RD: state_d = S_L_ESC;
			S_L_ESC: begin
				if (stat.esc_dec) state_d = S_N_FETCH;
				else if (!stat.esc_mapped && stat.room_two) state_d = S_L_UNK;
				else state_d = S_L_FETCH;
			end
			S_L_UNK:    state_d = S_L_FETCH;
			S_N_FETCH:  state_d = stat.p_end ? S_N_END : S_N_EX;
			S_N_EX:     state_d = stat.num_dec ? S_N_FETCH : S_N_END;
			S_N_END:    state_d = S_L_FETCH;
			// emit
			S_E_RD:     state_d = stat.elen_zero ? S_E_NONE : S_E_OUT;
			S_E_OUT: begin
				if (stat.out_space) state_d = stat.emit_last ? S_LOAD : S_E_RD;
			end
			S_E_NONE: begin
				if (stat.out_space) state_d = S_LOAD;
			end
			default: state_d = S_LOAD;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = 1'b0;
		cmd.op    = OP_NONE;
		cmd.clear = 1'b0;
		unique case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			S_DECIDE: begin
				if (stat.no_content) cmd.op = OP_PREP_STATUS;
				else if (stat.hex_ok) cmd.op = OP_HEX_BEGIN;
				else if (stat.literal_mode) cmd.op = OP_LIT_BEGIN;
			end
			S_HASH_CHK: cmd.op = stat.is_hash ? OP_HASH_BEGIN : OP_LIT_BEGIN;
			S_X_HI:     cmd.op = OP_HEX_HI;
			S_X_LO:     cmd.op = OP_HEX_LO;
			S_H_EX: begin
				if (!stat.hash_stop) cmd.op = OP_HASH_STEP;
			end
			S_H_WR_HI:  cmd.op = OP_HASH_WR_HI;
			S_H_WR_LO:  cmd.op = OP_HASH_WR_LO;
			S_L_FETCH: begin
				if (stat.p_end || stat.pos_full) cmd.op = OP_LIT_END;
			end
			S_L_EX: begin
				if (stat.is_bsl && !stat.bsl_trailing) cmd.op = OP_LIT_SKIP;
				else cmd.op = OP_LIT_CHAR;
			end
			S_L_ESC:    cmd.op = OP_LIT_ESC;
			S_L_UNK:    cmd.op = OP_LIT_UNK;
			S_N_EX: begin
				if (stat.num_dec) cmd.op = OP_NUM_STEP;
			end
			S_N_END:    cmd.op = OP_NUM_END;
			S_E_OUT: begin
				if (stat.out_space) begin
					cmd.op    = OP_EMIT_BYTE;
					cmd.clear = stat.emit_last;
				end
			end
			S_E_NONE: begin
				if (stat.out_space) begin
					cmd.op    = OP_EMIT_STATUS;
					cmd.clear = 1'b1;
				end
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== design/ssd_datapath.sv =====
// Datapath: config registers, character store, decode registers, selector buffer, output.
`timescale 1ns / 1ps
module ssd_datapath import ssd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  logic              in_empty,
	input  ctl_cmd_t          cmd,
	output dp_status_t        stat,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic [5:0]        byte_index,
	output logic              out_last,
	output logic              out_valid_byte,
	output logic [1:0]        form,
	output logic [1:0]        status,
	output logic [6:0]        result_count
);

	// Configuration and load state
	logic              literal_mode_q;
	logic [CFG_DW-1:0] sel_len_q;
	logic [CCW-1:0]    count_q;
	logic              all_hex_q;
	logic              ovf_q;
	logic              term_q;

	// Stores
	logic [7:0] char_mem [MAX_CHARS];
	logic [7:0] sel_buf  [MAX_SEL];
	logic [7:0] chr_rd_q;
	logic [7:0] buf_rd_q;

	// Walk pointers
	logic [CCW-1:0] p_q;
	logic [SCW-1:0] pos_q;
	logic [SCW-1:0] idx_q;

	// Decode registers
	logic [3:0]  nib_q;
	logic [15:0] hacc_q;
	logic        neg_q;
	logic        phase_q;   // 0: leading blanks and sign, 1: digits
	logic [6:0]  nacc_q;
	logic        base10_q;
	logic [7:0]  esc_q;

	// Result descriptor
	logic [1:0]     form_q;
	logic [1:0]     stat_q;
	logic [SCW-1:0] count_res_q;
	logic [SCW-1:0] elen_q;
	logic [SCW-1:0] bfill_q;

	// Output register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [5:0] out_idx_q;
	logic       out_last_q;
	logic       out_vb_q;
	logic [1:0] out_form_q;
	logic [1:0] out_stat_q;
	logic [6:0] out_cnt_q;

	// Combinational helpers
	logic [SCW-1:0] nsel;
	logic [CCW-2:0] half;
	logic [SCW-1:0] hex_cnt;
	logic [SCW-1:0] hash_len;
	logic [7:0]     c;
	logic           c_dec;
	logic           c_ws;
	logic           c_sign;
	logic [3:0]     c_digit;
	logic [15:0]    hash_val;
	logic [15:0]    hacc_next;
	logic [6:0]     nacc_next;
	logic           char_we;
	logic           buf_we;
	logic [SAW-1:0] buf_waddr;
	logic [7:0]     buf_wdata;
	logic           out_space;

	assign c       = chr_rd_q;
	assign c_dec   = is_dec(c);
	assign c_ws    = is_ws(c);
	assign c_sign  = (c == CH_PLUS) || (c == CH_MINUS);
	assign c_digit = 4'(c - CH_ZERO);

	assign nsel     = (sel_len_q > CFG_DW'(MAX_SEL)) ? SCW'(MAX_SEL) : SCW'(sel_len_q);
	assign half     = count_q[CCW-1:1];
	assign hex_cnt  = (CCW'(nsel) < CCW'(half)) ? nsel : SCW'(half);
	assign hash_len = (nsel < SCW'(2)) ? nsel : SCW'(2);

	assign hash_val  = neg_q ? (16'd0 - hacc_q) : hacc_q;
	assign hacc_next = (hacc_q << 3) + (hacc_q << 1) + 16'(c_digit);
	assign nacc_next = (base10_q ? ((nacc_q << 3) + (nacc_q << 1)) : (nacc_q << 3)) +
		7'(c_digit);

	assign out_space = !out_valid_q || out_ready;

	assign char_we = (cmd.op == OP_LOAD) && !in_empty && !term_q && (in_char != CH_NUL) &&
		(count_q < CCW'(MAX_CHARS));

	// Status to the sequencer
	always_comb begin
		stat.in_end       = in_empty || in_last;
		stat.no_content   = ovf_q || (count_q == '0);
		stat.hex_ok       = !literal_mode_q && all_hex_q && (count_q >= CCW'(2)) && !count_q[0];
		stat.literal_mode = literal_mode_q;
		stat.is_hash      = (c == CH_HASH);
		stat.p_end        = (p_q >= count_q);
		stat.pos_full     = (pos_q >= nsel);
		stat.hex_done     = (pos_q >= bfill_q);
		stat.hash_stop    = phase_q ? !c_dec : !(c_ws || c_sign || c_dec);
		stat.is_bsl       = (c == CH_BSL);
		stat.bsl_trailing = (({1'b0, p_q} + (CCW + 1)'(1)) >= {1'b0, count_q});
		stat.esc_dec      = c_dec;
		stat.esc_mapped   = esc_known(c);
		stat.room_two     = ((pos_q + SCW'(1)) < nsel);
		stat.num_dec      = c_dec;
		stat.elen_zero    = (elen_q == '0);
		stat.emit_last    = ((idx_q + SCW'(1)) == elen_q);
		stat.out_space    = out_space;
	end

	// Selector buffer write port
	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = pos_q[SAW-1:0];
		buf_wdata = c;
		case (cmd.op)
			OP_HEX_LO: begin
				buf_we    = 1'b1;
				buf_wdata = {nib_q, hex_nib(c)};
			end
			OP_HASH_WR_HI: begin
				buf_we    = 1'b1;
				buf_waddr = '0;
				buf_wdata = hash_val[15:8];
			end
			OP_HASH_WR_LO: begin
				buf_we    = 1'b1;
				buf_waddr = SAW'(1);
				buf_wdata = hash_val[7:0];
			end
			OP_LIT_CHAR: buf_we = 1'b1;
			OP_LIT_ESC: begin
				buf_we    = !c_dec;
				buf_wdata = esc_known(c) ? esc_map(c) : CH_BSL;
			end
			OP_LIT_UNK: begin
				buf_we    = 1'b1;
				buf_wdata = esc_q;
			end
			OP_NUM_END: begin
				buf_we    = 1'b1;
				buf_wdata = {1'b0, nacc_q};
			end
			default: buf_we = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			literal_mode_q <= 1'b0;
			sel_len_q      <= SEL_LEN_RESET;
			count_q        <= '0;
			all_hex_q      <= 1'b1;
			ovf_q          <= 1'b0;
			term_q         <= 1'b0;
			p_q            <= '0;
			pos_q          <= '0;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_LITERAL_MODE:    literal_mode_q <= cfg_wdata[0];
					REG_SELECTOR_LENGTH: sel_len_q      <= cfg_wdata;
				endcase
			end

			case (cmd.op)
				OP_LOAD: begin
					if (!in_empty && !term_q) begin
						if (in_char == CH_NUL) begin
							term_q <= 1'b1;
						end else if (count_q < CCW'(MAX_CHARS)) begin
							count_q <= count_q + CCW'(1);
							if (!is_hex(in_char)) all_hex_q <= 1'b0;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				OP_HEX_BEGIN, OP_LIT_BEGIN: begin
					p_q   <= '0;
					pos_q <= '0;
				end
				OP_HASH_BEGIN: p_q <= CCW'(1);
				OP_HEX_HI, OP_HASH_STEP, OP_LIT_SKIP, OP_NUM_STEP: p_q <= p_q + CCW'(1);
				OP_HEX_LO, OP_LIT_CHAR: begin
					p_q   <= p_q + CCW'(1);
					pos_q <= pos_q + SCW'(1);
				end
				OP_LIT_ESC: begin
					p_q <= p_q + CCW'(1);
					if (!c_dec) pos_q <= pos_q + SCW'(1);
				end
				OP_LIT_UNK, OP_NUM_END: pos_q <= pos_q + SCW'(1);
				OP_EMIT_BYTE: idx_q <= idx_q + SCW'(1);
				default: ;
			endcase

			// end of string: back to the empty load state
			if (cmd.clear) begin
				count_q   <= '0;
				all_hex_q <= 1'b1;
				ovf_q     <= 1'b0;
				term_q    <= 1'b0;
				p_q       <= '0;
				pos_q     <= '0;
				idx_q     <= '0;
			end

			if ((cmd.op == OP_EMIT_BYTE) || (cmd.op == OP_EMIT_STATUS)) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Character store, one write and one registered read
	always_ff @(posedge clk) begin
		if (char_we) char_mem[count_q[CAW-1:0]] <= in_char;
		chr_rd_q <= char_mem[p_q[CAW-1:0]];
	end

	// Selector buffer, one write and one registered read
	always_ff @(posedge clk) begin
		if (buf_we) sel_buf[buf_waddr] <= buf_wdata;
		buf_rd_q <= sel_buf[idx_q[SAW-1:0]];
	end

	// Decode and output payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_PREP_STATUS: begin
				stat_q      <= ovf_q ? STAT_OVF : STAT_EMPTY;
				form_q      <= FORM_HEX;
				count_res_q <= '0;
				elen_q      <= '0;
				bfill_q     <= '0;
			end
			OP_HEX_BEGIN: begin
				stat_q      <= STAT_OK;
				form_q      <= FORM_HEX;
				count_res_q <= hex_cnt;
				elen_q      <= nsel;
				bfill_q     <= hex_cnt;
			end
			OP_HEX_HI: nib_q <= hex_nib(c);
			OP_HASH_BEGIN: begin
				stat_q      <= STAT_OK;
				form_q      <= FORM_HASH;
				count_res_q <= SCW'(2);
				elen_q      <= hash_len;
				bfill_q     <= SCW'(2);
				hacc_q      <= '0;
				neg_q       <= 1'b0;
				phase_q     <= 1'b0;
			end
			OP_HASH_STEP: begin
				if (phase_q) begin
					hacc_q <= hacc_next;
				end else if (c_sign) begin
					neg_q   <= (c == CH_MINUS);
					phase_q <= 1'b1;
				end else if (c_dec) begin
					hacc_q  <= hacc_next;
					phase_q <= 1'b1;
				end
			end
			OP_LIT_BEGIN: begin
				stat_q <= STAT_OK;
				form_q <= FORM_LIT;
			end
			OP_LIT_ESC: begin
				esc_q    <= c;
				nacc_q   <= 7'(c_digit);
				base10_q <= (c != CH_ZERO);
			end
			OP_NUM_STEP: nacc_q <= nacc_next;
			OP_LIT_END: begin
				count_res_q <= pos_q;
				elen_q      <= pos_q;
				bfill_q     <= pos_q;
			end
			OP_EMIT_BYTE: begin
				out_byte_q <= (idx_q < bfill_q) ? buf_rd_q : 8'd0;
				out_idx_q  <= 6'(idx_q);
				out_last_q <= stat.emit_last;
				out_vb_q   <= 1'b1;
				out_form_q <= form_q;
				out_stat_q <= stat_q;
				out_cnt_q  <= 7'(count_res_q);
			end
			OP_EMIT_STATUS: begin
				out_byte_q <= 8'd0;
				out_idx_q  <= 6'd0;
				out_last_q <= 1'b1;
				out_vb_q   <= 1'b0;
				out_form_q <= form_q;
				out_stat_q <= stat_q;
				out_cnt_q  <= 7'(count_res_q);
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign byte_index     = out_idx_q;
	assign out_last       = out_last_q;
	assign out_valid_byte = out_vb_q;
	assign form           = out_form_q;
	assign status         = out_stat_q;
	assign result_count   = out_cnt_q;

endmodule

// ===== tb/sv/tb_selector_string_decoder_top.sv =====
// Self-checking testbench for the selector string decoder top level.
`timescale 1ns / 1ps
module tb_selector_string_decoder_top;
	import ssd_pkg::*;

	localparam int MAX_WAIT      = 6;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 16;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_REQS   = 230;

	// Escape translations
	localparam logic [7:0] ESC_BS  = 8'h08;
	localparam logic [7:0] ESC_FF  = 8'h0c;
	localparam logic [7:0] ESC_LF  = 8'h0a;
	localparam logic [7:0] ESC_CR  = 8'h0d;
	localparam logic [7:0] ESC_TAB = 8'h09;

	typedef logic [7:0] char_q_t [$];

	typedef struct packed {
		logic [7:0] sel_byte;
		logic [5:0] pos;
		logic       last;
		logic       has_data;
		logic [1:0] form_code;
		logic [1:0] stat;
		logic [6:0] count;
	} sel_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [CFG_AW-1:0] cfg_addr  = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [7:0]        in_char   = '0;
	logic              in_last   = 1'b0;
	logic              in_empty  = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [7:0]        out_byte;
	logic [5:0]        byte_index;
	logic              out_last;
	logic              out_valid_byte;
	logic [1:0]        form;
	logic [1:0]        status;
	logic [6:0]        result_count;

	// Predictor state: string being loaded and register copies
	logic [7:0]  str_chars [MAX_CHARS];
	int unsigned str_len      = 0;
	bit          str_all_hex  = 1'b1;
	bit          str_too_long = 1'b0;
	bit          str_nul_seen = 1'b0;
	bit          cfg_literal  = 1'b0;
	logic [6:0]  cfg_sel_len  = SEL_LEN_RESET;
	sel_result_t expected_results [$];

	// Run bookkeeping
	bit          steady          = 1'b0;
	int unsigned live_reqs       = 0;
	int unsigned strings_done    = 0;
	int unsigned results_checked = 0;
	int unsigned cfg_writes      = 0;
	int unsigned fail_count      = 0;
	int unsigned cycle_count     = 0;

	selector_string_decoder_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_char        (in_char),
		.in_last        (in_last),
		.in_empty       (in_empty),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_index     (byte_index),
		.out_last       (out_last),
		.out_valid_byte (out_valid_byte),
		.form           (form),
		.status         (status),
		.result_count   (result_count)
	);

	always #5 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				expected_results.size());
			$display("selector_string_decoder_top regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic bit is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic int nibble_value(input logic [7:0] c);
		if ((c >= "0") && (c <= "9")) return c - "0";
		if ((c >= "a") && (c <= "f")) return c - "a" + 10;
		if ((c >= "A") && (c <= "F")) return c - "A" + 10;
		return -1;
	endfunction

	function automatic sel_result_t status_only(input logic [1:0] f, input logic [1:0] st,
		input int unsigned cnt);
		return '{8'd0, 6'd0, 1'b1, 1'b0, f, st, 7'(cnt)};
	endfunction

	// One result per written byte; a status-only result when nothing is written
	function automatic void push_bytes(input logic [7:0] bytes_in [MAX_SEL],
		input int unsigned n, input logic [1:0] f, input int unsigned cnt);
		if (n == 0) begin
			expected_results.push_back(status_only(f, STAT_OK, cnt));
		end else begin
			for (int i = 0; i < n; i++)
				expected_results.push_back('{bytes_in[i], 6'(i), (i + 1 == n), 1'b1, f,
					STAT_OK, 7'(cnt)});
		end
	endfunction

	// Selector bytes for the string just ended
	function automatic void predict_selector();
		logic [7:0]  sel_buf [MAX_SEL];
		int unsigned nsel, len, m, cnt, p, q, pos;
		logic [31:0] v, acc, base;
		logic [7:0]  c, d, b0;
		bit          neg, two;
		nsel = (cfg_sel_len > MAX_SEL) ? MAX_SEL : cfg_sel_len;
		len = str_len;
		foreach (sel_buf[i]) sel_buf[i] = '0;
		if (str_too_long) begin
			expected_results.push_back(status_only(FORM_HEX, STAT_OVF, 0));
		end else if (len == 0) begin
			expected_results.push_back(status_only(FORM_HEX, STAT_EMPTY, 0));
		end else if (!cfg_literal && str_all_hex && len >= 2 && len % 2 == 0) begin
			// hex pairs, truncated to the selector and zero padded
			m = (len > 2 * nsel) ? 2 * nsel : len;
			cnt = m / 2;
			for (int i = 0; i < cnt; i++)
				sel_buf[i] = 8'(nibble_value(str_chars[2*i]) * 16 +
					nibble_value(str_chars[2*i+1]));
			push_bytes(sel_buf, nsel, FORM_HEX, cnt);
		end else if (!cfg_literal && str_chars[0] == CH_HASH) begin
			// decimal after '#': white space, sign, digits
			v = 0;
			neg = 1'b0;
			p = 1;
			while (p < len && (str_chars[p] == CH_SPACE ||
				(str_chars[p] >= 8'h09 && str_chars[p] <= 8'h0d)))
				p++;
			if (p < len && (str_chars[p] == CH_PLUS || str_chars[p] == CH_MINUS)) begin
				neg = (str_chars[p] == CH_MINUS);
				p++;
			end
			while (p < len && is_digit(str_chars[p])) begin
				v = v * 10 + 32'(str_chars[p] - CH_ZERO);
				p++;
			end
			if (neg) v = 32'd0 - v;
			sel_buf[0] = v[15:8];
			sel_buf[1] = v[7:0];
			push_bytes(sel_buf, (nsel < 2) ? nsel : 2, FORM_HASH, 2);
		end else begin
			// copy with escapes decoded
			p = 0;
			pos = 0;
			while (p < len && pos < nsel) begin
				c = str_chars[p];
				if (c != CH_BSL || p + 1 >= len) begin
					sel_buf[pos] = c;
					pos++;
					p++;
				end else begin
					d = str_chars[p+1];
					p += 2;
					two = 1'b0;
					case (d)
						"b":     b0 = ESC_BS;
						"f":     b0 = ESC_FF;
						"n":     b0 = ESC_LF;
						"r":     b0 = ESC_CR;
						"t":     b0 = ESC_TAB;
						CH_BSL:  b0 = CH_BSL;
						default: begin
							if (is_digit(d)) begin
								// octal when the run starts with zero
								base = (d != CH_ZERO) ? 10 : 8;
								acc = 0;
								q = p - 1;
								while (q < len && is_digit(str_chars[q])) begin
									acc = acc * base + 32'(str_chars[q] - CH_ZERO);
									q++;
								end
								b0 = {1'b0, acc[6:0]};
								p = q;
							end else begin
								b0 = CH_BSL;
								two = 1'b1;
							end
						end
					endcase
					sel_buf[pos] = b0;
					pos++;
					// unknown escape keeps its character only if there is room
					if (two && pos < nsel) begin
						sel_buf[pos] = d;
						pos++;
					end
				end
			end
			push_bytes(sel_buf, pos, FORM_LIT, pos);
		end
	endfunction

	// Load one accepted request into the predictor
	function automatic void take_request(input logic [7:0] c, input logic last,
		input logic empty);
		if (empty || last || !str_nul_seen) live_reqs++;
		if (!empty && !str_nul_seen) begin
			if (c == CH_NUL) begin
				str_nul_seen = 1'b1;
			end else if (str_len < MAX_CHARS) begin
				str_chars[str_len] = c;
				str_len++;
				if (nibble_value(c) < 0) str_all_hex = 1'b0;
			end else begin
				str_too_long = 1'b1;
			end
		end
		if (empty || last) begin
			predict_selector();
			strings_done++;
			str_len = 0;
			str_all_hex = 1'b1;
			str_too_long = 1'b0;
			str_nul_seen = 1'b0;
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic char_q_t text(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	task automatic send_request(input logic [7:0] c, input logic last, input logic empty);
		int gap;
		gap = steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_char  <= c;
		in_last  <= last;
		in_empty <= empty;
		do @(posedge clk); while (!in_ready);
		take_request(c, last, empty);
	endtask

	// Whole string; an empty queue or end_with_empty closes it with an empty request
	task automatic send_string(input char_q_t chars, input bit end_with_empty);
		for (int i = 0; i < chars.size(); i++)
			send_request(chars[i], !end_with_empty && (i == chars.size() - 1), 1'b0);
		if (end_with_empty || chars.size() == 0)
			send_request(8'($urandom), 1'($urandom), 1'b1);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_LITERAL_MODE) cfg_literal = value[0];
		else cfg_sel_len = value;
		cfg_writes++;
	endtask

	// ---------------------------------------------------------------- result checker

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	initial begin : result_monitor
		int          stall;
		sel_result_t got, want;
		wait (arst_n === 1'b1);
		forever begin
			stall = steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{out_byte, byte_index, out_last, out_valid_byte, form, status,
				result_count};
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, actual byte %0h index %0d status %0d",
					$time, got.sel_byte, got.pos, got.stat);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("out_byte", want.sel_byte, got.sel_byte);
				check_field("byte_index", want.pos, got.pos);
				check_field("out_last", want.last, got.last);
				check_field("out_valid_byte", want.has_data, got.has_data);
				check_field("form", want.form_code, got.form_code);
				check_field("status", want.stat, got.stat);
				check_field("result_count", want.count, got.count);
			end
			results_checked++;
		end
	end

	// ---------------------------------------------------------------- tests

	// Hex, hash, literal, empty and terminator handling at reset settings and in literal mode
	task automatic test_forms();
		char_q_t chars;
		send_string(text("0aF9"), 1'b0);
		send_string(text("A"), 1'b0);
		send_string(text("abc"), 1'b0);
		send_string(chars, 1'b0);
		send_string(text("#  -42x"), 1'b0);
		send_string(text("#99999999999"), 1'b0);
		send_string(text("#"), 1'b0);
		// zero character ends the content, the rest is ignored
		chars = text("12");
		chars.push_back(CH_NUL);
		chars = {chars, text("34")};
		send_string(chars, 1'b0);
		chars = '{CH_NUL};
		send_string(chars, 1'b0);
		send_string(text("x\\"), 1'b1);
		chars = '{8'hff, 8'h80, 8'h01};
		send_string(chars, 1'b0);
		write_reg(REG_LITERAL_MODE, 1);
		send_string(text("0a1b"), 1'b0);
		send_string(text("#12"), 1'b0);
		write_reg(REG_LITERAL_MODE, 0);
	endtask

	// Every escape kind
	task automatic test_escapes();
		char_q_t chars;
		send_string(text("\\b\\f\\n\\r\\t\\\\"), 1'b0);
		send_string(text("a\\"), 1'b0);
		send_string(text("\\0177\\08\\19\\200x"), 1'b0);
		send_string(text("\\q\\%"), 1'b0);
		send_string(text("\\99999999999"), 1'b0);
		chars = '{CH_BSL, 8'hfe};
		send_string(chars, 1'b0);
	endtask

	// Zero, one and two byte selectors, and a length above the buffer size
	task automatic test_selector_sizes();
		write_reg(REG_SELECTOR_LENGTH, 0);
		send_string(text("ab"), 1'b0);
		send_string(text("#5"), 1'b0);
		send_string(text("xyz"), 1'b0);
		write_reg(REG_SELECTOR_LENGTH, 1);
		send_string(text("#258"), 1'b0);
		send_string(text("\\q"), 1'b0);
		send_string(text("a1b2c3"), 1'b0);
		write_reg(REG_SELECTOR_LENGTH, 2);
		send_string(text("z\\q"), 1'b0);
		write_reg(REG_SELECTOR_LENGTH, 127);
		send_string(text("12"), 1'b0);
		write_reg(REG_SELECTOR_LENGTH, SEL_LEN_RESET);
	endtask

	// Full character store, overflow, and a terminator ahead of an overlong tail
	task automatic test_long_strings();
		char_q_t chars;
		for (int i = 0; i < MAX_CHARS; i++)
			chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		send_string(chars, 1'b0);
		chars.delete();
		for (int i = 0; i < MAX_CHARS + 2; i++)
			chars.push_back(8'($urandom_range(8'h20, 8'h7e)));
		send_string(chars, 1'b0);
		chars[5] = CH_NUL;
		send_string(chars, 1'b1);
		write_reg(REG_LITERAL_MODE, 1);
		chars.delete();
		for (int i = 0; i < 100; i++)
			chars.push_back(8'($urandom_range(8'h21, 8'h7e)));
		send_string(chars, 1'b0);
		write_reg(REG_LITERAL_MODE, 0);
	endtask

	// Random strings of every form under changing settings and idling
	task automatic test_random();
		char_q_t     chars;
		string       hex_set;
		int unsigned first_req, n, kind, len;
		hex_set = "0123456789abcdefABCDEF";
		first_req = live_reqs;
		n = 0;
		while (live_reqs - first_req < RANDOM_REQS) begin
			// new settings every few strings
			if (n % 10 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
				write_reg(REG_LITERAL_MODE, ($urandom_range(0, 3) == 0));
				case ($urandom_range(0, 6))
					0: write_reg(REG_SELECTOR_LENGTH, 0);
					1: write_reg(REG_SELECTOR_LENGTH, 1);
					2: write_reg(REG_SELECTOR_LENGTH, 2);
					3: write_reg(REG_SELECTOR_LENGTH, 7'($urandom_range(3, 16)));
					4: write_reg(REG_SELECTOR_LENGTH, MAX_SEL);
					5: write_reg(REG_SELECTOR_LENGTH, 7'($urandom_range(65, 127)));
					default: write_reg(REG_SELECTOR_LENGTH, 7'($urandom_range(17, 63)));
				endcase
			end
			chars.delete();
			kind = $urandom_range(0, 99);
			if (kind < 25) begin
				// even-length hex, now and then longer than the selector
				len = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(5, 66)
					: 2 * $urandom_range(1, 4);
				repeat (len) chars.push_back(hex_set[$urandom_range(0, 21)]);
			end else if (kind < 45) begin
				// hash decimal with optional white space, sign and tail
				chars.push_back(CH_HASH);
				repeat ($urandom_range(0, 2))
					chars.push_back($urandom_range(0, 1) ? CH_SPACE
						: 8'($urandom_range(9, 13)));
				case ($urandom_range(0, 2))
					0: chars.push_back(CH_PLUS);
					1: chars.push_back(CH_MINUS);
					default: ;
				endcase
				repeat ($urandom_range(0, 11))
					chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				if ($urandom_range(0, 3) == 0) chars.push_back(8'($urandom_range(1, 255)));
			end else if (kind < 75) begin
				// plain characters mixed with escapes
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: chars.push_back(8'($urandom_range(8'h20, 8'h7e)));
						1: chars = {chars, CH_BSL, text("bfnrt\\")[$urandom_range(0, 5)]};
						2: begin
							chars.push_back(CH_BSL);
							chars.push_back($urandom_range(0, 1) ? CH_ZERO
								: 8'(CH_ZERO + $urandom_range(0, 9)));
							repeat ($urandom_range(0, 3))
								chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
						end
						default: begin
							chars.push_back(CH_BSL);
							chars.push_back(8'($urandom_range(1, 255)));
						end
					endcase
				end
				if ($urandom_range(0, 4) == 0) chars.push_back(CH_BSL);
			end else if (kind < 88) begin
				// raw bytes, zero included
				repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom));
			end else if (kind < 95) begin
				// odd-length hex falls through to the literal form
				repeat (2 * $urandom_range(0, 3) + 1)
					chars.push_back(hex_set[$urandom_range(0, 21)]);
			end
			send_string(chars, ($urandom_range(0, 7) == 0));
			n++;
		end
		steady = 1'b0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_forms();
		test_escapes();
		test_selector_sizes();
		test_long_strings();
		test_random();
		wait_idle();
		$display("Checked %0d results from %0d strings across %0d register writes.",
			results_checked, strings_done, cfg_writes);
		$display("Hex, hash and escaped forms, empty and oversize strings, short selectors.");
		if (fail_count == 0) begin
			$display("selector_string_decoder_top regression: pass");
		end else begin
			$display("selector_string_decoder_top regression: fail");
		end
		$finish;
	end

endmodule
